// File: rtl/core/quadruple_vm_execute_unit_macros.svh
// Assertion macros for the quadruple VM execute unit
`ifndef QUADRUPLE_VM_EXECUTE_UNIT_MACROS_SVH
`define QUADRUPLE_VM_EXECUTE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define QVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QVM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QVM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/qvm_pkg.sv
// ----------------------------------------------------------------------------
// qvm_pkg
// Shared types and codes for the quadruple VM execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
package qvm_pkg;
    localparam logic [3:0] OPC_GOTO = 4'd0;
    localparam logic [3:0] OPC_IN   = 4'd2;
    localparam logic [3:0] OPC_PRT  = 4'd3;
    localparam logic [3:0] OPC_PRTN = 4'd4;
    localparam logic [3:0] OPC_BLT  = 4'd5;
    localparam logic [3:0] OPC_BLE  = 4'd6;
    localparam logic [3:0] OPC_BGT  = 4'd7;
    localparam logic [3:0] OPC_BGE  = 4'd8;
    localparam logic [3:0] OPC_BEQ  = 4'd9;
    localparam logic [3:0] OPC_BNE  = 4'd10;
    localparam logic [3:0] OPC_MOV  = 4'd11;
    localparam logic [3:0] OPC_ADD  = 4'd12;
    localparam logic [3:0] OPC_SUB  = 4'd13;
    localparam logic [3:0] OPC_MUL  = 4'd14;
    localparam logic [3:0] OPC_DIV  = 4'd15;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_JMP0  = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RDA, S_RDB, S_WAIT, S_EXEC, S_DIV, S_WRITE, S_OUT
    } state_t;

    // Divider control and status
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
    } div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/core/qvm_divider.sv
// ----------------------------------------------------------------------------
// qvm_divider
// Radix-2 restoring signed divider, one quotient bit a cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadruple_vm_execute_unit_macros.svh"
module qvm_divider (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire qvm_pkg::div_req_t  req,
    output qvm_pkg::div_rsp_t       rsp
);
    import qvm_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    // Load the operands on start, then step the subtractor once a cycle while busy
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[31]};
        trial     = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num[31] ? (32'd0 - req.num) : req.num;
            den_next  = req.den[31] ? (32'd0 - req.den) : req.den;
            neg_next  = req.num[31] ^ req.den[31];
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
                rem_next = trial[31:0];
            else
                rem_next = shifted[31:0];
            quo_next = {quo_reg[30:0], ~trial[32]};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? (32'd0 - quo_reg) : quo_reg;

    `QVM_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg)
    `QVM_ASSERT_NXT(a_start_busy, clk, rst_n, req.start, busy_reg)
    `QVM_ASSERT_IMP(a_cnt_zero, clk, rst_n, !busy_reg, cnt_reg == 6'd0)
endmodule
`default_nettype wire

// File: rtl/core/quadruple_vm_execute_unit.sv
// ----------------------------------------------------------------------------
// quadruple_vm_execute_unit
// Quadruple instruction executor over a word data memory.
// ----------------------------------------------------------------------------
// Usage: present an item on in_valid/in_ready; operation 0 preloads one word,
// operation 1 executes one instruction. One result transaction follows every
// item on out_valid/out_ready, carrying next_pc, print data and status.
// A preload writes its word in S_RDA and goes straight to S_OUT. Other
// instructions step through S_RDA, S_RDB, S_WAIT, S_EXEC, S_WRITE and S_OUT;
// a divide adds S_DIV after S_EXEC, where the one-bit-a-cycle divider runs
// its 32 steps. A divide by zero skips the divider. The data memory has
// one read and one write port, so the two operands are read in consecutive
// cycles. One item is in flight at a time; in_ready is low until its result
// is taken, so no new item is accepted before then. While the receiver
// stalls the result stays registered and stable. After reset a clearing
// pass zeroes the memory, one word a cycle, before the first item is
// accepted. The program counter resets to zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadruple_vm_execute_unit_macros.svh"
module quadruple_vm_execute_unit #(
    parameter int DATA_WORDS = 1024,
    parameter int PROG_WORDS = 1024
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire               operation,
    input  wire  [3:0]        opcode,
    input  wire  [9:0]        operand_a,
    input  wire  [9:0]        operand_b,
    input  wire  [9:0]        operand_c,
    input  wire signed [31:0] word_value,
    output logic              out_valid,
    input  wire               out_ready,
    output logic [9:0]        next_pc,
    output logic              print_valid,
    output logic signed [31:0] print_value,
    output logic              print_newline,
    output logic [1:0]        status
);
    import qvm_pkg::*;

    localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int PW = (PROG_WORDS > 1) ? $clog2(PROG_WORDS) : 1;

    state_t state_reg, state_next;
    logic [31:0] mem [DATA_WORDS];
    logic [AW:0] clr_reg, clr_next;
    logic [31:0] rdata;
    logic [AW-1:0] raddr;
    logic        we;
    logic [AW-1:0] waddr;
    logic [31:0] wdata;

    logic        op_reg;
    logic [3:0]  opc_reg;
    logic [9:0]  a_reg, b_reg, c_reg;
    logic [31:0] val_reg;
    logic [31:0] x_reg, x_next, y_reg, y_next;
    logic [31:0] res_reg, res_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic        wen_reg, wen_next;
    logic [9:0]  pc_reg, pc_next;
    logic [9:0]  npc_reg, npc_next;
    logic        pv_reg, pv_next, pnl_reg, pnl_next;
    logic [31:0] pval_reg, pval_next;
    logic [1:0]  st_reg, st_next;
    div_req_t    dreq;
    div_rsp_t    drsp;

    logic        jump;
    logic        lt_xy, lt_yx;
    logic [PW-1:0] pc_inc, pc_jmp;

    qvm_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // Data memory, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

    assign lt_xy = $signed(x_reg) < $signed(y_reg);
    assign lt_yx = $signed(y_reg) < $signed(x_reg);
    assign pc_inc = PW'(pc_reg) + PW'(1);

    always_comb
    begin
        jump = 1'b0;
        case (opc_reg)
            OPC_GOTO: jump = 1'b1;
            OPC_BLT:  jump = lt_xy;
            OPC_BLE:  jump = !lt_yx;
            OPC_BGT:  jump = lt_yx;
            OPC_BGE:  jump = !lt_xy;
            OPC_BEQ:  jump = x_reg == y_reg;
            OPC_BNE:  jump = x_reg != y_reg;
            default:  jump = 1'b0;
        endcase
        if (opc_reg == OPC_GOTO)
            pc_jmp = PW'(a_reg - 10'd1);
        else
            pc_jmp = PW'(c_reg - 10'd1);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        x_next = x_reg; y_next = y_reg; res_next = res_reg;
        wa_next = wa_reg; wen_next = 1'b0;
        pc_next = pc_reg; npc_next = npc_reg;
        pv_next = pv_reg; pnl_next = pnl_reg; pval_next = pval_reg; st_next = st_reg;
        we = 1'b0; waddr = wa_reg; wdata = res_reg;
        raddr = AW'(a_reg);
        dreq.start = 1'b0; dreq.num = x_reg; dreq.den = y_reg;
        in_ready = 1'b0; out_valid = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1; waddr = clr_reg[AW-1:0]; wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(DATA_WORDS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = S_RDA;
            end
            S_RDA:
            begin
                raddr = AW'(a_reg);
                pv_next = 1'b0; pnl_next = 1'b0; pval_next = '0; st_next = ST_OK;
                if (!op_reg)
                begin
                    we = 1'b1; waddr = AW'(a_reg); wdata = val_reg;
                    npc_next = pc_reg;
                    state_next = S_OUT;
                end
                else
                    state_next = S_RDB;
            end
            S_RDB:
            begin
                raddr = AW'(b_reg);
                x_next = rdata;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                y_next = rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                wen_next = 1'b0;
                wa_next = AW'(c_reg);
                res_next = x_reg;
                npc_next = 10'(pc_inc);
                case (opc_reg)
                    OPC_IN:   begin wen_next = 1'b1; wa_next = AW'(a_reg); res_next = val_reg; end
                    OPC_PRT:  begin pv_next = 1'b1; pval_next = x_reg; end
                    OPC_PRTN: begin pv_next = 1'b1; pval_next = x_reg; pnl_next = 1'b1; end
                    OPC_MOV:  begin wen_next = 1'b1; wa_next = AW'(b_reg); end
                    OPC_ADD:  begin wen_next = 1'b1; res_next = x_reg + y_reg; end
                    OPC_SUB:  begin wen_next = 1'b1; res_next = x_reg - y_reg; end
                    OPC_MUL:  begin wen_next = 1'b1; res_next = x_reg * y_reg; end
                    default:  ;
                endcase
                if (jump)
                begin
                    if ((opc_reg == OPC_GOTO ? a_reg : c_reg) == 10'd0)
                        st_next = ST_JMP0;
                    else
                        npc_next = 10'(pc_jmp);
                end
                if (opc_reg == OPC_DIV)
                begin
                    if (y_reg == 32'd0)
                        st_next = ST_DIV0;
                    else
                    begin
                        dreq.start = 1'b1;
                        state_next = S_DIV;
                    end
                end
                if (state_next == S_EXEC)
                    state_next = S_WRITE;
                pc_next = npc_next;
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    res_next = drsp.quot;
                    wen_next = 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                we = wen_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            wen_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            wen_reg   <= wen_next;
        end
    end

    // Capture the item and hold working values
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= operation;
            opc_reg <= opcode;
            a_reg   <= operand_a;
            b_reg   <= operand_b;
            c_reg   <= operand_c;
            val_reg <= word_value;
        end
        x_reg <= x_next; y_reg <= y_next; res_reg <= res_next; wa_reg <= wa_next;
        npc_reg <= npc_next; pv_reg <= pv_next; pnl_reg <= pnl_next;
        pval_reg <= pval_next; st_reg <= st_next;
    end

    assign next_pc       = npc_reg;
    assign print_valid   = pv_reg;
    assign print_value   = pval_reg;
    assign print_newline = pnl_reg;
    assign status        = st_reg;

    `QVM_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
    `QVM_ASSERT_IMP(a_div_state, clk, rst_n, drsp.busy, state_reg == S_DIV)
    `QVM_ASSERT_IMP(a_st_range, clk, rst_n, out_valid, status != 2'd3)
endmodule
`default_nettype wire
